>>> rtl/core/ral_pkg.sv
// ============================================================================
// Rocker auto-repeat level control package
// Shared types, key codes, request codes and register indexes.
// ============================================================================
package ral_pkg;

    localparam int TIME_BITS     = 32;
    localparam int LEVEL_BITS    = 8;
    localparam int DELAY_BITS    = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;

    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [LEVEL_BITS-1:0]    t_level;
    typedef logic [DELAY_BITS-1:0]    t_delay;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_POLL_START = 2'd0,
        REQ_KEY_EVENT  = 2'd1,
        REQ_POLL_END   = 2'd2
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VOL_LIMIT        = 3'd0,
        CFG_BRI_LIMIT        = 3'd1,
        CFG_FIRST_DELAY      = 3'd2,
        CFG_REPEAT_INTERVAL  = 3'd3,
        CFG_SLEEP_GAP        = 3'd4,
        CFG_VOLUME_START     = 3'd5,
        CFG_BRIGHTNESS_START = 3'd6
    } t_cfg_idx;

    // Key codes and event type.
    localparam logic [9:0] KEY_UP     = 10'd115;
    localparam logic [9:0] KEY_DOWN   = 10'd114;
    localparam logic [9:0] KEY_HOTKEY = 10'd316;
    localparam logic [9:0] KEY_SELECT = 10'd314;
    localparam logic [9:0] KEY_START  = 10'd315;
    localparam logic [4:0] EV_KEY        = 5'd1;
    localparam logic [7:0] KEY_VAL_MAX   = 8'd2;

    // Register reset values.
    localparam t_level VOL_LIMIT_RST        = 8'd20;
    localparam t_level BRI_LIMIT_RST        = 8'd10;
    localparam t_delay FIRST_DELAY_RST      = 16'd300;
    localparam t_delay REPEAT_INTERVAL_RST  = 16'd100;
    localparam t_delay SLEEP_GAP_RST        = 16'd1000;
    localparam t_level VOLUME_START_RST     = 8'd0;
    localparam t_level BRIGHTNESS_START_RST = 8'd0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [31:0] now_ms;
        logic [4:0] event_type;
        logic [9:0] key_code;
        logic [7:0] key_value;
        logic       kill_target_present;
    } t_ral_in;

    typedef struct packed {
        logic [7:0] volume_level;
        logic [7:0] brightness_level;
        logic       kill_request;
        logic       input_ignored;
    } t_ral_out;

    typedef struct packed {
        t_level vol_limit;
        t_level bri_limit;
        t_delay first_repeat_delay_ms;
        t_delay repeat_interval_ms;
        t_delay sleep_gap_ms;
    } t_ral_cfg;

    // One rocker key: held and fresh keep only whether the key value was nonzero.
    typedef struct packed {
        logic  held;
        logic  fresh;
        t_time deadline;
    } t_rocker;

    typedef struct packed {
        logic    ignore_flag;
        t_time   poll_time;
        t_time   last_poll_time;
        logic    hotkey_held;
        logic    select_held;
        logic    start_held;
        t_rocker up;
        t_rocker down;
        t_level  volume;
        t_level  brightness;
    } t_ral_state;

endpackage

>>> rtl/core/rocker_autorepeat_level_control.sv
// ============================================================================
// Rocker auto-repeat level control
// A transfer accepted into the input register moves on to the output
// register when that register is empty or its result is being taken.
// One transfer per cycle is sustained while results are taken every cycle.
// Reset (synchronous, active low) empties both stages, restores register
// defaults and clears all key state; levels load their start values.
// ============================================================================
//
// The block tracks a volume and a brightness level stepped by an up/down
// rocker with auto-repeat. Polls arrive as a poll start (latches time and
// flags stale input), key events (update held-key state) and a poll end
// (applies steps, reports a kill request). The hotkey redirects the rocker
// to brightness. Every transfer returns exactly one result.
//
// Pipeline: an input register holds the accepted transfer; the step logic
// computes the next state and the result in one pass, and the result goes
// to an output register. While a finished result waits in the output
// register, the input register can still take one transfer; after that the
// input stalls until the waiting result is taken.
module rocker_autorepeat_level_control
    import ral_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_ral_in                 i_in,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_ral_out                o_out,
    // Configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  t_cfg_data               i_cfg_data
);

    logic       r_in_valid;
    t_ral_in    r_in;
    logic       r_out_valid;
    t_ral_out   r_out;
    t_ral_state r_state;
    t_ral_cfg   r_cfg;

    t_ral_state n_state;
    t_ral_out   n_out;
    logic       advance;
    t_ral_state state_rst;

    // The held transfer moves on when the output register is empty or
    // its result is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // State after reset: all key state clear, levels at their start values.
    always_comb begin
        state_rst            = '0;
        state_rst.volume     = VOLUME_START_RST;
        state_rst.brightness = BRIGHTNESS_START_RST;
    end

    ral_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Block state and configuration. Writes must come only while the block
    // is idle so they never collide with a state update; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                     <= state_rst;
            r_cfg.vol_limit             <= VOL_LIMIT_RST;
            r_cfg.bri_limit             <= BRI_LIMIT_RST;
            r_cfg.first_repeat_delay_ms <= FIRST_DELAY_RST;
            r_cfg.repeat_interval_ms    <= REPEAT_INTERVAL_RST;
            r_cfg.sleep_gap_ms          <= SLEEP_GAP_RST;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOL_LIMIT:        r_cfg.vol_limit <= i_cfg_data[LEVEL_BITS-1:0];
                    CFG_BRI_LIMIT:        r_cfg.bri_limit <= i_cfg_data[LEVEL_BITS-1:0];
                    CFG_FIRST_DELAY:      r_cfg.first_repeat_delay_ms <= i_cfg_data;
                    CFG_REPEAT_INTERVAL:  r_cfg.repeat_interval_ms <= i_cfg_data;
                    CFG_SLEEP_GAP:        r_cfg.sleep_gap_ms <= i_cfg_data;
                    // Writing a start value also loads the level at once.
                    CFG_VOLUME_START:     r_state.volume <= i_cfg_data[LEVEL_BITS-1:0];
                    CFG_BRIGHTNESS_START: r_state.brightness <= i_cfg_data[LEVEL_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/ral_step.sv
// ============================================================================
// Rocker step logic
// Computes the next state and the result of one transfer from the current state.
// ============================================================================
module ral_step
    import ral_pkg::*;
(
    input  t_ral_in    i_item,
    input  t_ral_state i_state,
    input  t_ral_cfg   i_cfg,
    output t_ral_state o_state,
    output t_ral_out   o_result
);

    t_time   now_t;
    t_time   press_deadline;
    logic    key_ok;
    logic    pressed;
    logic    hot_c;
    t_rocker up_c;
    t_rocker dn_c;
    logic    up_step;
    logic    dn_step;
    t_rocker up_n;
    t_rocker dn_n;
    t_level  lvl_in;
    t_level  lvl_max;
    t_level  lvl_up;
    t_level  lvl_dn;
    logic    kill;
    logic    ign;

    assign now_t          = t_time'(i_item.now_ms);
    assign press_deadline = i_state.poll_time + t_time'(i_cfg.first_repeat_delay_ms);
    assign key_ok  = !i_state.ignore_flag && (i_item.event_type == EV_KEY)
                     && (i_item.key_value <= KEY_VAL_MAX);
    assign pressed = (i_item.key_value != '0);

    // Poll end: stale polls drop hotkey and rocker state before stepping.
    assign hot_c = i_state.hotkey_held & ~i_state.ignore_flag;
    assign up_c  = i_state.ignore_flag ? '0 : i_state.up;
    assign dn_c  = i_state.ignore_flag ? '0 : i_state.down;

    assign up_step = up_c.fresh | (up_c.held & (i_state.poll_time >= up_c.deadline));
    assign dn_step = dn_c.fresh | (dn_c.held & (i_state.poll_time >= dn_c.deadline));

    always_comb begin
        up_n = up_c;
        if (up_step) begin
            if (up_c.fresh) begin
                up_n.fresh = 1'b0;
            end else begin
                up_n.deadline = up_c.deadline + t_time'(i_cfg.repeat_interval_ms);
            end
        end
        dn_n = dn_c;
        if (dn_step) begin
            if (dn_c.fresh) begin
                dn_n.fresh = 1'b0;
            end else begin
                dn_n.deadline = dn_c.deadline + t_time'(i_cfg.repeat_interval_ms);
            end
        end
    end

    // Up is applied before down on the same level.
    assign lvl_in  = hot_c ? i_state.brightness : i_state.volume;
    assign lvl_max = hot_c ? i_cfg.bri_limit : i_cfg.vol_limit;
    assign lvl_up  = (up_step && (lvl_in < lvl_max)) ? lvl_in + 8'd1 : lvl_in;
    assign lvl_dn  = (dn_step && (lvl_up != '0)) ? lvl_up - 8'd1 : lvl_up;

    always_comb begin
        o_state = i_state;
        kill    = 1'b0;
        ign     = i_state.ignore_flag;
        unique case (i_item.req_type)
            REQ_POLL_START: begin
                o_state.poll_time   = now_t;
                o_state.ignore_flag = (now_t - i_state.last_poll_time)
                                      > t_time'(i_cfg.sleep_gap_ms);
                ign = o_state.ignore_flag;
            end
            REQ_KEY_EVENT: begin
                if (key_ok) begin
                    unique case (i_item.key_code)
                        KEY_HOTKEY: o_state.hotkey_held = pressed;
                        KEY_SELECT: o_state.select_held = pressed;
                        KEY_START:  o_state.start_held  = pressed;
                        KEY_UP: begin
                            o_state.up.held  = pressed;
                            o_state.up.fresh = pressed;
                            if (pressed) begin
                                o_state.up.deadline = press_deadline;
                            end
                        end
                        KEY_DOWN: begin
                            o_state.down.held  = pressed;
                            o_state.down.fresh = pressed;
                            if (pressed) begin
                                o_state.down.deadline = press_deadline;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_POLL_END: begin
                kill = i_item.kill_target_present & i_state.start_held
                       & i_state.select_held;
                o_state.hotkey_held = hot_c;
                o_state.up          = up_n;
                o_state.down        = dn_n;
                if (hot_c) begin
                    o_state.brightness = lvl_dn;
                end else begin
                    o_state.volume = lvl_dn;
                end
                o_state.last_poll_time = i_state.poll_time;
                o_state.ignore_flag    = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_result.volume_level     = o_state.volume;
    assign o_result.brightness_level = o_state.brightness;
    assign o_result.kill_request     = kill;
    assign o_result.input_ignored    = ign;

endmodule

>>> test/rocker_autorepeat_level_control_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Rocker auto-repeat level control testbench
// Feeds poll starts, key events and poll ends through the valid/ready input,
// predicts every result with an in-bench copy of the level logic and checks
// each result transfer against the oldest prediction. Runs a short directed
// table, then randomized poll sequences under several register settings.
// ============================================================================
module rocker_autorepeat_level_control_test;
    import ral_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam logic [4:0] EV_NONE      = 5'd0;
    localparam logic [7:0] KV_RELEASE   = 8'd0;
    localparam logic [7:0] KV_PRESS     = 8'd1;
    localparam logic [7:0] KV_REPEAT    = 8'd2;

    // Number of randomized transfers per register setting, six settings.
    localparam int unsigned PHASE_ITEMS = 130;
    localparam int unsigned HOLD_CYCLES = 200;

    typedef struct packed {
        t_ral_in  item;
        logic     typed;
        t_ral_out want;
    } t_dir_row;

    // Directed table. Rows with typed set carry a result that follows directly
    // from the reset settings; the others are checked against the predictor.
    localparam t_dir_row DIRECTED [25] = '{
        // Fresh poll at time zero, then an up press that steps volume once.
        '{'{REQ_POLL_START, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b1,
          '{8'd0, 8'd0, 1'b0, 1'b0}},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_UP, KV_PRESS, 1'b0}, 1'b1,
          '{8'd0, 8'd0, 1'b0, 1'b0}},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b1,
          '{8'd1, 8'd0, 1'b0, 1'b0}},
        // One millisecond short of the first repeat, then exactly on it.
        '{'{REQ_POLL_START, 32'd299, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_START, 32'd300, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        // Hotkey held: a down repeat would lower brightness, which sits at zero.
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_HOTKEY, KV_PRESS, 1'b0}, 1'b0, '0},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_DOWN, KV_REPEAT, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        // Events that must be dropped: not a key event, value out of range.
        '{'{REQ_KEY_EVENT, 32'd0, 5'd31, KEY_UP, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_UP, 8'd255, 1'b0}, 1'b0, '0},
        // Select plus start plus a target gives a kill request.
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_SELECT, KV_PRESS, 1'b0}, 1'b0, '0},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_START, KV_PRESS, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b1}, 1'b1,
          '{8'd2, 8'd0, 1'b1, 1'b0}},
        // A huge gap marks the poll stale; its key events are discarded and
        // the poll end clears rocker and hotkey state but still reports kill.
        '{'{REQ_POLL_START, 32'hFFFF_FFFF, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b1,
          '{8'd2, 8'd0, 1'b0, 1'b1}},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_UP, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b1}, 1'b1,
          '{8'd2, 8'd0, 1'b1, 1'b1}},
        // Unused request code with every field at its top value.
        '{'{REQ_RESERVED, 32'hFFFF_FFFF, 5'd31, 10'd1023, 8'd255, 1'b1}, 1'b1,
          '{8'd2, 8'd0, 1'b0, 1'b0}},
        // Deadline that wraps past the top of the time range.
        '{'{REQ_POLL_START, 32'hFFFF_FFFF, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_UP, KV_PRESS, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_START, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_KEY_EVENT, 32'd0, EV_KEY, KEY_SELECT, KV_RELEASE, 1'b0}, 1'b0, '0},
        '{'{REQ_POLL_END, 32'd0, EV_NONE, 10'd0, KV_RELEASE, 1'b1}, 1'b0, '0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    t_ral_in                 in_data;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_ral_out                out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    t_cfg_data               cfg_data;

    // Sideband that travels with each input transfer: a typed-in result for
    // directed rows, which then replaces the predicted one.
    logic                    row_typed;
    t_ral_out                row_want;

    // Predictor state, register copy and the results still owed by the block.
    t_ral_state              lvl_state;
    t_ral_cfg                lvl_cfg;
    t_ral_out                levels_due [$];

    int unsigned             fail_count = 0;
    int unsigned             items_sent = 0;
    int unsigned             tx_idle_pct;
    int unsigned             rx_idle_pct;
    int unsigned             hold_req = 0;
    int unsigned             hold_taken = 0;
    int unsigned             hold_left = 0;
    t_time                   sim_ms = '0;

    rocker_autorepeat_level_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturating one-step move of a level. Above the maximum an up step does
    // nothing, while a down step still lowers the level.
    function automatic t_level step_level(input t_level lvl, input t_level top,
                                          input logic raise);
        if (raise) begin
            return (lvl < top) ? lvl + 8'd1 : lvl;
        end
        return (lvl != '0) ? lvl - 8'd1 : lvl;
    endfunction

    // One rocker key at poll end. A fresh press steps at once and loses its
    // fresh mark; a held key steps when the poll time has reached its
    // deadline, which then moves on by the repeat interval.
    function automatic t_rocker apply_rocker(input t_rocker key, input logic raise);
        if (key.fresh || (key.held && lvl_state.poll_time >= key.deadline)) begin
            if (lvl_state.hotkey_held) begin
                lvl_state.brightness = step_level(lvl_state.brightness,
                                                  lvl_cfg.bri_limit, raise);
            end else begin
                lvl_state.volume = step_level(lvl_state.volume, lvl_cfg.vol_limit, raise);
            end
            if (key.fresh) begin
                key.fresh = 1'b0;
            end else begin
                key.deadline = key.deadline + t_time'(lvl_cfg.repeat_interval_ms);
            end
        end
        return key;
    endfunction

    // Advances the predicted state by one input transfer and returns the
    // result that transfer must produce.
    function automatic t_ral_out advance_levels(input t_ral_in x);
        t_ral_out res;
        t_time    gap;
        logic     down_now;
        res = '0;
        res.input_ignored = lvl_state.ignore_flag;
        case (x.req_type)
            REQ_POLL_START: begin
                lvl_state.poll_time   = x.now_ms;
                gap                   = x.now_ms - lvl_state.last_poll_time;
                lvl_state.ignore_flag = gap > t_time'(lvl_cfg.sleep_gap_ms);
                res.input_ignored     = lvl_state.ignore_flag;
            end
            REQ_KEY_EVENT: begin
                if (!lvl_state.ignore_flag && x.event_type == EV_KEY &&
                        x.key_value <= KEY_VAL_MAX) begin
                    down_now = (x.key_value != KV_RELEASE);
                    case (x.key_code)
                        KEY_HOTKEY: lvl_state.hotkey_held = down_now;
                        KEY_SELECT: lvl_state.select_held = down_now;
                        KEY_START:  lvl_state.start_held  = down_now;
                        KEY_UP: begin
                            lvl_state.up.held  = down_now;
                            lvl_state.up.fresh = down_now;
                            if (down_now) begin
                                lvl_state.up.deadline = lvl_state.poll_time +
                                    t_time'(lvl_cfg.first_repeat_delay_ms);
                            end
                        end
                        KEY_DOWN: begin
                            lvl_state.down.held  = down_now;
                            lvl_state.down.fresh = down_now;
                            if (down_now) begin
                                lvl_state.down.deadline = lvl_state.poll_time +
                                    t_time'(lvl_cfg.first_repeat_delay_ms);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_POLL_END: begin
                // A stale poll drops the hotkey and both rocker keys; select
                // and start survive, so a kill can still be reported.
                if (lvl_state.ignore_flag) begin
                    lvl_state.hotkey_held = 1'b0;
                    lvl_state.up          = '0;
                    lvl_state.down        = '0;
                end
                res.kill_request = x.kill_target_present && lvl_state.start_held &&
                                   lvl_state.select_held;
                lvl_state.up             = apply_rocker(lvl_state.up, 1'b1);
                lvl_state.down           = apply_rocker(lvl_state.down, 1'b0);
                lvl_state.last_poll_time = lvl_state.poll_time;
                lvl_state.ignore_flag    = 1'b0;
            end
            default: ;
        endcase
        res.volume_level     = lvl_state.volume;
        res.brightness_level = lvl_state.brightness;
        return res;
    endfunction

    // Offers one transfer and returns at the edge where it is accepted. Valid
    // is only lowered when the sender decides to idle before this item.
    task automatic send_transfer(input t_ral_in item, input logic typed,
                                 input t_ral_out want);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid  <= 1'b1;
        in_data   <= item;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // One poll: a start with a time step chosen to land short of, on, or past
    // the sleep gap, a few key events, and usually an end. Unused fields carry
    // random bits. A small share is pure noise or leaves out the poll end.
    task automatic send_random_poll();
        t_ral_in     item;
        logic [63:0] raw;
        t_time       step;
        int unsigned pick;
        int unsigned keys;
        raw  = {$urandom, $urandom};
        item = raw[$bits(t_ral_in)-1:0];
        if ($urandom_range(99) < 8) begin
            send_transfer(item, 1'b0, '0);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            step = $urandom_range(0, 150);
        end else if (pick < 85) begin
            step = t_time'(lvl_cfg.sleep_gap_ms) + t_time'($urandom_range(0, 2)) - t_time'(1);
        end else begin
            step = $urandom;
        end
        sim_ms        = sim_ms + step;
        item.req_type = REQ_POLL_START;
        item.now_ms   = sim_ms;
        send_transfer(item, 1'b0, '0);

        keys = $urandom_range(0, 3);
        repeat (keys) begin
            raw           = {$urandom, $urandom};
            item          = raw[$bits(t_ral_in)-1:0];
            item.req_type = REQ_KEY_EVENT;
            if ($urandom_range(9) != 0) begin
                item.event_type = EV_KEY;
            end
            case ($urandom_range(0, 7))
                0, 1: item.key_code = KEY_UP;
                2, 3: item.key_code = KEY_DOWN;
                4:    item.key_code = KEY_HOTKEY;
                5:    item.key_code = KEY_SELECT;
                6:    item.key_code = KEY_START;
                default: ;
            endcase
            if ($urandom_range(9) != 0) begin
                item.key_value = 8'($urandom_range(0, 2));
            end
            send_transfer(item, 1'b0, '0);
        end

        if ($urandom_range(19) != 0) begin
            raw           = {$urandom, $urandom};
            item          = raw[$bits(t_ral_in)-1:0];
            item.req_type = REQ_POLL_END;
            send_transfer(item, 1'b0, '0);
        end
    endtask

    // Waits until every predicted result has come back, then a few more
    // cycles so that a stray extra result would still be caught.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        while (levels_due.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (levels_due.size() != 0) begin
            if (fail_count < 10) begin
                $display("tb: %0d results never arrived", levels_due.size());
            end
            fail_count += levels_due.size();
            levels_due.delete();
        end
    endtask

    // Register write, mirrored into the predictor. Writing a start value also
    // loads the level itself.
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_VOL_LIMIT:        lvl_cfg.vol_limit             = value[LEVEL_BITS-1:0];
            CFG_BRI_LIMIT:        lvl_cfg.bri_limit             = value[LEVEL_BITS-1:0];
            CFG_FIRST_DELAY:      lvl_cfg.first_repeat_delay_ms = value;
            CFG_REPEAT_INTERVAL:  lvl_cfg.repeat_interval_ms    = value;
            CFG_SLEEP_GAP:        lvl_cfg.sleep_gap_ms          = value;
            CFG_VOLUME_START:     lvl_state.volume              = value[LEVEL_BITS-1:0];
            CFG_BRIGHTNESS_START: lvl_state.brightness          = value[LEVEL_BITS-1:0];
            default: ;
        endcase
    endtask

    // Every accepted input transfer is run through the predictor here, at
    // the edge where it is taken. Directed rows with a typed result queue
    // that result instead, but still advance the predicted state.
    always @(posedge clk) begin : accept_side
        t_ral_out predicted;
        if (rst_n && in_valid && in_ready) begin
            predicted = advance_levels(in_data);
            levels_due.push_back(row_typed ? row_want : predicted);
        end
    end

    // Every result transfer is compared with the oldest outstanding one.
    always @(posedge clk) begin : result_side
        t_ral_out want;
        if (rst_n && out_valid && out_ready) begin
            if (levels_due.size() == 0) begin
                if (fail_count < 10) begin
                    $display("tb: unexpected result vol=%0d bri=%0d kill=%0b ign=%0b",
                             out_data.volume_level, out_data.brightness_level,
                             out_data.kill_request, out_data.input_ignored);
                end
                fail_count++;
            end else begin
                want = levels_due.pop_front();
                if (out_data.volume_level !== want.volume_level ||
                        out_data.brightness_level !== want.brightness_level ||
                        out_data.kill_request !== want.kill_request ||
                        out_data.input_ignored !== want.input_ignored) begin
                    if (fail_count < 10) begin
                        $display("tb: mismatch exp vol=%0d bri=%0d kill=%0b ign=%0b",
                                 want.volume_level, want.brightness_level,
                                 want.kill_request, want.input_ignored);
                        $display("tb:          got vol=%0d bri=%0d kill=%0b ign=%0b",
                                 out_data.volume_level, out_data.brightness_level,
                                 out_data.kill_request, out_data.input_ignored);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Result side ready. Normally random at the current idle rate; when the
    // stimulus asks for a hold-off, ready stays low for a long stretch so the
    // block backs up and has to stall its input.
    always @(posedge clk) begin : receiver
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_taken != hold_req) begin
            hold_taken++;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        t_cfg_data   regs_val [7];
        int unsigned phase;
        int unsigned phase_end;
        int unsigned r;
        logic        hold_asked;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        row_typed = 1'b0;
        row_want  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_VOL_LIMIT;
        cfg_data  = '0;
        hold_asked = 1'b0;

        // Predictor starts from the reset register values and empty key state.
        lvl_cfg.vol_limit             = VOL_LIMIT_RST;
        lvl_cfg.bri_limit             = BRI_LIMIT_RST;
        lvl_cfg.first_repeat_delay_ms = FIRST_DELAY_RST;
        lvl_cfg.repeat_interval_ms    = REPEAT_INTERVAL_RST;
        lvl_cfg.sleep_gap_ms          = SLEEP_GAP_RST;
        lvl_state                     = '0;
        lvl_state.volume              = VOLUME_START_RST;
        lvl_state.brightness          = BRIGHTNESS_START_RST;

        tx_idle_pct = 10;
        rx_idle_pct = 47;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k]) begin
            send_transfer(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].want);
        end

        // Six register settings: two at the extremes, the rest random, with
        // 8-bit registers also seeing junk in their upper data bits. Idling
        // goes sender-light first, then receiver-light, then none at all.
        for (phase = 0; phase < 6; phase++) begin
            in_valid <= 1'b0;
            drain_results();
            case (phase)
                0: begin
                    regs_val[CFG_VOL_LIMIT]        = 16'hFFFF;
                    regs_val[CFG_BRI_LIMIT]        = 16'h00FF;
                    regs_val[CFG_FIRST_DELAY]      = 16'd0;
                    regs_val[CFG_REPEAT_INTERVAL]  = 16'd0;
                    regs_val[CFG_SLEEP_GAP]        = 16'hFFFF;
                    regs_val[CFG_VOLUME_START]     = 16'd250;
                    regs_val[CFG_BRIGHTNESS_START] = 16'hFFFF;
                end
                1: begin
                    regs_val[CFG_VOL_LIMIT]        = 16'hFF00;
                    regs_val[CFG_BRI_LIMIT]        = 16'd0;
                    regs_val[CFG_FIRST_DELAY]      = 16'hFFFF;
                    regs_val[CFG_REPEAT_INTERVAL]  = 16'hFFFF;
                    regs_val[CFG_SLEEP_GAP]        = 16'd0;
                    regs_val[CFG_VOLUME_START]     = 16'd3;
                    regs_val[CFG_BRIGHTNESS_START] = 16'd255;
                end
                5: begin
                    for (r = 0; r < 7; r++) begin
                        regs_val[r] = 16'($urandom);
                    end
                end
                default: begin
                    regs_val[CFG_VOL_LIMIT] = {8'($urandom), 8'($urandom_range(0, 30))};
                    regs_val[CFG_BRI_LIMIT] =
                        {8'($urandom), 8'($urandom_range(0, 15))};
                    regs_val[CFG_FIRST_DELAY]     = 16'($urandom_range(0, 400));
                    regs_val[CFG_REPEAT_INTERVAL] = 16'($urandom_range(0, 200));
                    regs_val[CFG_SLEEP_GAP]       = 16'($urandom_range(100, 1500));
                    regs_val[CFG_VOLUME_START] = {8'($urandom), 8'($urandom_range(0, 40))};
                    regs_val[CFG_BRIGHTNESS_START] =
                        {8'($urandom), 8'($urandom_range(0, 20))};
                end
            endcase
            for (r = 0; r < 7; r++) begin
                write_reg(t_cfg_idx'(r), regs_val[r]);
            end
            cfg_we <= 1'b0;

            case (phase / 2)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                // With both sides running flat out, one long receiver hold-off
                // makes the block fill up while the sender keeps offering.
                if (phase == 4 && !hold_asked && items_sent + 90 >= phase_end) begin
                    hold_asked = 1'b1;
                    hold_req++;
                end
                send_random_poll();
            end
        end

        in_valid <= 1'b0;
        drain_results();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
